// ===== src/background_tile_pixel_render_core_macros.svh =====
// Assertion macros shared by the render core.
`ifndef BACKGROUND_TILE_PIXEL_RENDER_CORE_MACROS_SVH
`define BACKGROUND_TILE_PIXEL_RENDER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BTPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btpr: implication check failed");
`define BTPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btpr: next-cycle check failed");
`else
`define BTPR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BTPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/btpr_pkg.sv =====
package btpr_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF = 160;
  localparam int unsigned VRAM_BYTES       = 8192;
  localparam int unsigned VRAM_AW          = $clog2(VRAM_BYTES);
  localparam int unsigned BANK_DEPTH       = VRAM_BYTES / 2;
  localparam int unsigned BANK_AW          = $clog2(BANK_DEPTH);

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_SELECT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SELECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE     = 3'd4;

  localparam logic [7:0] PALETTE_RESET = 8'd252;

  // Tile map bases as byte offsets into video memory: 2'b11 selects the
  // upper quarter, the next bit picks between the two maps.
  localparam logic [1:0] MAP_AREA = 2'b11;

  localparam logic [7:0] GRAY_LUT [4] = '{8'd255, 8'd170, 8'd85, 8'd0};

  typedef struct packed {
    logic               en;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         data;
  } vram_wr_t;

endpackage

// ===== src/btpr_vram.sv =====
module btpr_vram (
  input  logic                      clk,
  input  btpr_pkg::vram_wr_t        wr,
  input  logic                      map_rd_en,
  input  logic [btpr_pkg::BANK_AW-1:0] map_rd_idx,
  input  logic                      dat_rd_en,
  input  logic [btpr_pkg::BANK_AW-1:0] dat_rd_idx,
  output logic [7:0]                map_even_q,
  output logic [7:0]                map_odd_q,
  output logic [7:0]                dat_even_q,
  output logic [7:0]                dat_odd_q
);
  import btpr_pkg::*;

  // Even and odd bytes live in separate banks so that one tile row, which
  // always starts at an even address, is read as a pair with a single access.
  logic [7:0] even_mem [BANK_DEPTH];
  logic [7:0] odd_mem  [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en && !wr.addr[0]) begin
      even_mem[wr.addr[VRAM_AW-1:1]] <= wr.data;
    end
    if (wr.en && wr.addr[0]) begin
      odd_mem[wr.addr[VRAM_AW-1:1]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (map_rd_en) begin
      map_even_q <= even_mem[map_rd_idx];
      map_odd_q  <= odd_mem[map_rd_idx];
    end
    if (dat_rd_en) begin
      dat_even_q <= even_mem[dat_rd_idx];
      dat_odd_q  <= odd_mem[dat_rd_idx];
    end
  end

endmodule

// ===== src/background_tile_pixel_render_core.sv =====
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+-------------------------
// request   | in_func in_vram_addr in_vram_data in_pixel_x   | start high, busy low
//           | in_line_y                                      |
// result    | out_x out_y out_color_index out_gray_level     | out_valid for one cycle
// config    | cfg_index cfg_data                             | cfg_valid and cfg_ready
//
// One request is taken every cycle while busy is low; busy is set only by reset.
// A render result passes the stage A, B and C registers and then the output register:
// the map byte and then the tile row pair are each a registered video memory bank read.
// A write request is registered in stage A, then written to memory; it yields no result.
// Reset clears the pipeline and loads register defaults; video memory is not cleared.
// The pipeline never stalls, since results cannot be held off.
`include "background_tile_pixel_render_core_macros.svh"

module background_tile_pixel_render_core #(
  parameter int unsigned SCREEN_WIDTH = btpr_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_func,
  input  logic [btpr_pkg::VRAM_AW-1:0]     in_vram_addr,
  input  logic [7:0]                       in_vram_data,
  input  logic [7:0]                       in_pixel_x,
  input  logic [7:0]                       in_line_y,
  output logic                             out_valid,
  output logic [7:0]                       out_x,
  output logic [7:0]                       out_y,
  output logic [1:0]                       out_color_index,
  output logic [7:0]                       out_gray_level,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [btpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_data
);
  import btpr_pkg::*;

  localparam logic [12:0] WIDTH_W = 13'(SCREEN_WIDTH);

  function automatic logic [7:0] wrap_col(input logic [7:0] px);
    logic [12:0] rem;
    rem = {5'd0, px};
    for (int k = 4; k >= 0; k--) begin
      if (rem >= (WIDTH_W << k)) begin
        rem = rem - (WIDTH_W << k);
      end
    end
    return rem[7:0];
  endfunction

  logic       busy_r;
  logic [7:0] scroll_x_r;
  logic [7:0] scroll_y_r;
  logic       map_select_r;
  logic       data_select_r;
  logic [7:0] palette_r;

  logic               accept;
  logic               a_vld_r;
  logic               a_func_r;
  logic [VRAM_AW-1:0] a_addr_r;
  logic [7:0]         a_data_r;
  logic [7:0]         a_x_r;
  logic [7:0]         a_y_r;

  logic [7:0]         a_sx;
  logic [7:0]         a_sy;
  logic [VRAM_AW-1:0] a_map_addr;
  logic               a_render;
  vram_wr_t           a_wr;

  logic       b_vld_r;
  logic [7:0] b_x_r;
  logic [7:0] b_y_r;
  logic [2:0] b_fine_x_r;
  logic [2:0] b_fine_y_r;
  logic       b_map_odd_r;

  logic [7:0]         b_tile;
  logic [BANK_AW-1:0] b_row_idx;

  logic       c_vld_r;
  logic [7:0] c_x_r;
  logic [7:0] c_y_r;
  logic [2:0] c_fine_x_r;

  logic [1:0] c_color;
  logic [1:0] c_shade;

  logic       out_valid_r;
  logic [7:0] out_x_r;
  logic [7:0] out_y_r;
  logic [1:0] out_color_r;
  logic [7:0] out_gray_r;

  logic [7:0] map_even_q;
  logic [7:0] map_odd_q;
  logic [7:0] dat_even_q;
  logic [7:0] dat_odd_q;

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r    <= '0;
      scroll_y_r    <= '0;
      map_select_r  <= 1'b0;
      data_select_r <= 1'b0;
      palette_r     <= PALETTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCROLL_X:    scroll_x_r    <= cfg_data;
        REG_SCROLL_Y:    scroll_y_r    <= cfg_data;
        REG_MAP_SELECT:  map_select_r  <= cfg_data[0];
        REG_DATA_SELECT: data_select_r <= cfg_data[0];
        REG_PALETTE:     palette_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: request registered, column wrapped to the screen width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_func_r <= in_func;
      a_addr_r <= in_vram_addr;
      a_data_r <= in_vram_data;
      a_x_r    <= wrap_col(in_pixel_x);
      a_y_r    <= in_line_y;
    end
  end

  assign a_render   = a_vld_r && (a_func_r == FUNC_RENDER);
  assign a_sx       = a_x_r + scroll_x_r;
  assign a_sy       = a_y_r + scroll_y_r;
  assign a_map_addr = {MAP_AREA, map_select_r, a_sy[7:3], a_sx[7:3]};

  always_comb begin
    a_wr.en   = a_vld_r && (a_func_r == FUNC_WRITE);
    a_wr.addr = a_addr_r;
    a_wr.data = a_data_r;
  end

  // Stage B: map byte arrives, tile row address formed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_render;
    end
  end

  always_ff @(posedge clk) begin
    if (a_render) begin
      b_x_r       <= a_x_r;
      b_y_r       <= a_y_r;
      b_fine_x_r  <= a_sx[2:0];
      b_fine_y_r  <= a_sy[2:0];
      b_map_odd_r <= a_map_addr[0];
    end
  end

  assign b_tile = b_map_odd_r ? map_odd_q : map_even_q;

  // With signed addressing the tile number is rebased around the middle block:
  // negative numbers land in the middle block and positive ones above it.
  assign b_row_idx = {(data_select_r ? 1'b0 : ~b_tile[7]), b_tile, b_fine_y_r};

  // Stage C: row pair arrives, color and shade resolved.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      c_x_r      <= b_x_r;
      c_y_r      <= b_y_r;
      c_fine_x_r <= b_fine_x_r;
    end
  end

  assign c_color = {dat_odd_q[~c_fine_x_r], dat_even_q[~c_fine_x_r]};
  assign c_shade = palette_r[{c_color, 1'b0} +: 2];

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_vld_r) begin
      out_x_r     <= c_x_r;
      out_y_r     <= c_y_r;
      out_color_r <= c_color;
      out_gray_r  <= GRAY_LUT[c_shade];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_color_index = out_color_r;
  assign out_gray_level  = out_gray_r;

  btpr_vram u_vram (
    .clk        (clk),
    .wr         (a_wr),
    .map_rd_en  (a_render),
    .map_rd_idx (a_map_addr[VRAM_AW-1:1]),
    .dat_rd_en  (b_vld_r),
    .dat_rd_idx (b_row_idx),
    .map_even_q (map_even_q),
    .map_odd_q  (map_odd_q),
    .dat_even_q (dat_even_q),
    .dat_odd_q  (dat_odd_q)
  );

  `BTPR_ASSERT_NEXT(a_render_taken, clk, rst_n, accept && (in_func == FUNC_RENDER), a_render)
  `BTPR_ASSERT_NEXT(a_write_silent, clk, rst_n, a_vld_r && (a_func_r == FUNC_WRITE), !b_vld_r)
  `BTPR_ASSERT_IMPL(out_from_stage_b, clk, rst_n, out_valid_r, $past(b_vld_r, 2))
  `BTPR_ASSERT_IMPL(out_col_on_screen, clk, rst_n, out_valid_r, int'(out_x_r) < SCREEN_WIDTH)

endmodule

// ===== bench/background_tile_pixel_render_core_test.sv =====
`timescale 1ns / 1ps

module background_tile_pixel_render_core_test;
  import btpr_pkg::*;

  localparam int unsigned SCREEN_W = SCREEN_WIDTH_DEF;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [VRAM_AW-1:0] MAP_LOW_BASE = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP_HIGH_BASE = 13'h1C00;
  // Signed tile numbers -128..127 sit around offset 0x1000, so tile -128 starts at 0x0800.
  localparam logic [VRAM_AW-1:0] SIGNED_TILE_LOW = 13'h0800;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] color;
    logic [7:0] gray;
  } pixel_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_func = FUNC_WRITE;
  logic [VRAM_AW-1:0] in_vram_addr = '0;
  logic [7:0] in_vram_data = '0;
  logic [7:0] in_pixel_x = '0;
  logic [7:0] in_line_y = '0;
  logic out_valid;
  logic [7:0] out_x;
  logic [7:0] out_y;
  logic [1:0] out_color_index;
  logic [7:0] out_gray_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  logic [7:0] vram_image [VRAM_BYTES];
  bit vram_filled [VRAM_BYTES];
  logic [7:0] scroll_x_reg = 8'd0;
  logic [7:0] scroll_y_reg = 8'd0;
  logic map_sel_reg = 1'b0;
  logic data_sel_reg = 1'b0;
  logic [7:0] palette_reg = PALETTE_RESET;

  pixel_t expected_pixels[$];
  int unsigned idle_pct = 0;
  int unsigned requests_sent = 0;
  int unsigned pixels_rendered = 0;
  int unsigned bytes_stored = 0;
  int unsigned settings_applied = 0;
  int unsigned fail_count = 0;

  background_tile_pixel_render_core #(
    .SCREEN_WIDTH(SCREEN_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_vram_addr(in_vram_addr),
    .in_vram_data(in_vram_data),
    .in_pixel_x(in_pixel_x),
    .in_line_y(in_line_y),
    .out_valid(out_valid),
    .out_x(out_x),
    .out_y(out_y),
    .out_color_index(out_color_index),
    .out_gray_level(out_gray_level),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] screen_col(input logic [7:0] px);
    return 8'(px % SCREEN_W);
  endfunction

  function automatic logic [7:0] scrolled_x(input logic [7:0] px);
    logic [7:0] sx;
    sx = screen_col(px) + scroll_x_reg;
    return sx;
  endfunction

  function automatic logic [VRAM_AW-1:0] map_offset(input logic [7:0] px,
                                                   input logic [7:0] ly);
    logic [7:0] sx;
    logic [7:0] sy;
    sx = scrolled_x(px);
    sy = ly + scroll_y_reg;
    return (map_sel_reg ? MAP_HIGH_BASE : MAP_LOW_BASE) + {3'b0, sy[7:3], sx[7:3]};
  endfunction

  function automatic logic [VRAM_AW-1:0] row_offset(input logic [7:0] tile,
                                                   input logic [7:0] ly);
    logic [7:0] sy;
    logic [VRAM_AW-1:0] base;
    sy = ly + scroll_y_reg;
    if (data_sel_reg) begin
      base = {1'b0, tile, 4'h0};
    end else begin
      base = SIGNED_TILE_LOW + {1'b0, tile ^ 8'h80, 4'h0};
    end
    return base + {9'b0, sy[2:0], 1'b0};
  endfunction

  function automatic pixel_t predict_pixel(input logic [7:0] px, input logic [7:0] ly);
    pixel_t p;
    logic [VRAM_AW-1:0] row;
    logic [7:0] sx;
    logic [2:0] bitpos;
    logic [1:0] shade;
    sx = scrolled_x(px);
    row = row_offset(vram_image[map_offset(px, ly)], ly);
    bitpos = 3'd7 - sx[2:0];
    p.x = screen_col(px);
    p.y = ly;
    p.color = {vram_image[row + 13'd1][bitpos], vram_image[row][bitpos]};
    shade = palette_reg[{p.color, 1'b0} +: 2];
    p.gray = 8'd255 - 8'd85 * {6'd0, shade};
    return p;
  endfunction

  function automatic logic [7:0] pick_col();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(SCREEN_W - 1));
  endfunction

  function automatic logic [7:0] pick_line();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(143));
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: x %0d y %0d color %0d gray %0d",
               out_x, out_y, out_color_index, out_gray_level);
        fail_count++;
      end else begin
        pixel_t e;
        e = expected_pixels.pop_front();
        if (out_x !== e.x) begin
          $error("out_x: expected %0d, got %0d", e.x, out_x);
          fail_count++;
        end
        if (out_y !== e.y) begin
          $error("out_y: expected %0d, got %0d", e.y, out_y);
          fail_count++;
        end
        if (out_color_index !== e.color) begin
          $error("out_color_index: expected %0d, got %0d", e.color, out_color_index);
          fail_count++;
        end
        if (out_gray_level !== e.gray) begin
          $error("out_gray_level: expected %0d, got %0d", e.gray, out_gray_level);
          fail_count++;
        end
      end
    end
  end

  task automatic send_request(input logic func, input logic [VRAM_AW-1:0] addr,
                              input logic [7:0] data, input logic [7:0] px,
                              input logic [7:0] ly);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_vram_addr <= addr;
    in_vram_data <= data;
    in_pixel_x <= px;
    in_line_y <= ly;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    if (func == FUNC_WRITE) begin
      vram_image[addr] = data;
      vram_filled[addr] = 1'b1;
      bytes_stored++;
    end else begin
      expected_pixels.push_back(predict_pixel(px, ly));
      pixels_rendered++;
    end
  endtask

  task automatic store_byte(input logic [VRAM_AW-1:0] addr);
    send_request(FUNC_WRITE, addr, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
  endtask

  task automatic fill_byte(input logic [VRAM_AW-1:0] addr);
    if (!vram_filled[addr]) store_byte(addr);
  endtask

  // The map byte and both bitplane bytes are stored first wherever they are
  // still unwritten, so that no render ever reads undefined memory.
  task automatic render_pixel(input logic [7:0] px, input logic [7:0] ly);
    logic [VRAM_AW-1:0] map_at;
    logic [VRAM_AW-1:0] row_at;
    map_at = map_offset(px, ly);
    fill_byte(map_at);
    row_at = row_offset(vram_image[map_at], ly);
    fill_byte(row_at);
    fill_byte(row_at + 13'd1);
    send_request(FUNC_RENDER, VRAM_AW'($urandom_range(VRAM_BYTES - 1)),
                 8'($urandom_range(255)), px, ly);
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SCROLL_X: scroll_x_reg = val;
      REG_SCROLL_Y: scroll_y_reg = val;
      REG_MAP_SELECT: map_sel_reg = val[0];
      REG_DATA_SELECT: data_sel_reg = val[0];
      REG_PALETTE: palette_reg = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] sx, input logic [7:0] sy,
                                input logic map_sel, input logic data_sel,
                                input logic [7:0] pal, input bit stray_write);
    drain_pipeline();
    write_register(REG_SCROLL_X, sx);
    write_register(REG_SCROLL_Y, sy);
    write_register(REG_MAP_SELECT, {7'($urandom_range(127)), map_sel});
    write_register(REG_DATA_SELECT, {7'($urandom_range(127)), data_sel});
    if (stray_write) begin
      write_register(CFG_IDX_W'($urandom_range(REG_PALETTE + 1, REG_LAST_INDEX)),
                     8'($urandom_range(255)));
    end
    write_register(REG_PALETTE, pal);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic apply_random_settings();
    apply_settings(pick_byte(), pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   pick_byte(), $urandom_range(2) == 0);
  endtask

  task automatic test_reset_settings();
    render_pixel(8'd0, 8'd0);
    render_pixel(8'(SCREEN_W - 1), 8'd143);
    render_pixel(8'd255, 8'd255);
  endtask

  task automatic test_register_extremes();
    apply_settings(8'd255, 8'd255, 1'b1, 1'b1, 8'h1B, 1'b1);
    render_pixel(8'(SCREEN_W), 8'd144);
    render_pixel(8'(SCREEN_W - 1), 8'd0);
    apply_settings(8'd0, 8'd0, 1'b0, 1'b0, 8'hFF, 1'b0);
    render_pixel(8'd0, 8'd255);
  endtask

  task automatic test_random_traffic();
    int unsigned phase_end;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      apply_random_settings();
      phase_end = requests_sent + 140;
      while (requests_sent < phase_end) begin
        if ($urandom_range(99) < 70) begin
          render_pixel(pick_col(), pick_line());
        end else begin
          store_byte(VRAM_AW'($urandom_range(VRAM_BYTES - 1)));
        end
      end
    end
  endtask

  task automatic test_streaming();
    int unsigned run_end;
    idle_pct = 0;
    apply_random_settings();
    run_end = requests_sent + 150;
    while (requests_sent < run_end) begin
      if ($urandom_range(99) < 80) begin
        render_pixel(pick_col(), pick_line());
      end else begin
        store_byte(VRAM_AW'($urandom_range(VRAM_BYTES - 1)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_register_extremes();
    test_random_traffic();
    test_streaming();
    drain_pipeline();
    $display("Sent %0d requests: %0d pixels rendered, %0d bytes stored.",
             requests_sent, pixels_rendered, bytes_stored);
    $display("Register settings applied: %0d, %0d mismatches found.",
             settings_applied, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/btpr_pkg.sv
src/btpr_vram.sv
src/background_tile_pixel_render_core.sv
bench/background_tile_pixel_render_core_test.sv
